@@ hw/rtl/sliding_window_min_max_avg_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window min/max/average block
// Each macro expects clk and rst to be visible in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_AVG_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_AVG_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SWMMA_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SWMMA_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/swmma_pkg.sv @@
// ----------------------------------------------------------------------------
// swmma_pkg
// Shared constants, word types and control structs of the sliding window
// min/max/average block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swmma_pkg;

  // Window depth and derived widths
  localparam int WINDOW     = 64;
  localparam int ADDR_W     = $clog2(WINDOW);
  localparam int IDX_W      = ADDR_W + 1;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int SUM_W      = 31 + CNT_W;
  localparam int ITER_W     = $clog2(SUM_W + 1);
  localparam int OUT_CNT_W  = 7;
  localparam bit WIN_POW2   = ((WINDOW & (WINDOW - 1)) == 0);

  // Input word
  typedef struct packed {
    logic [31:0]        frame_index;
    logic signed [31:0] sample;
  } req_word_t;

  // Result word
  typedef struct packed {
    logic signed [31:0]    latest;
    logic [OUT_CNT_W-1:0]  valid_count;
    logic [30:0]           minimum;
    logic [30:0]           maximum;
    logic [30:0]           average;
  } rsp_word_t;

  // Window memory port controls
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } win_ctrl_t;

  // Divider start request
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

@@ hw/rtl/swmma_window.sv @@
// ----------------------------------------------------------------------------
// swmma_window
// Sample window memory with one write and one registered read port. Per-entry
// valid bits make never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swmma_window (
  input  logic                clk,
  input  logic                rst,
  input  swmma_pkg::win_ctrl_t ctrl,
  output logic [31:0]         rd_value
);
  import swmma_pkg::*;

  logic [31:0]       mem [WINDOW];
  logic [WINDOW-1:0] vbits;
  logic [31:0]       rd_data;
  logic              rd_vld;

  // Write the memory array and register the read data
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[ctrl.rd_addr];
      rd_vld  <= vbits[ctrl.rd_addr];
    end
  end

  // Mark written entries; reset clears the whole window at once
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (ctrl.wr_en) begin
      vbits[ctrl.wr_addr] <= 1'b1;
    end
  end

  // Drop the data of entries not yet written
  assign rd_value = rd_vld ? rd_data : 32'd0;

endmodule

@@ hw/rtl/swmma_div.sv @@
// ----------------------------------------------------------------------------
// swmma_div
// Restoring divider, one quotient bit per cycle. Serves both the slot
// reduction of the frame index and the final average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_min_max_avg_assert.svh"

module swmma_div (
  input  logic                        clk,
  input  logic                        rst,
  input  swmma_pkg::div_req_t         req,
  output logic                        done,
  output logic [swmma_pkg::SUM_W-1:0] quotient,
  output logic [swmma_pkg::CNT_W-1:0] remainder
);
  import swmma_pkg::*;

  logic              busy;
  logic [ITER_W-1:0] cnt;
  logic [SUM_W-1:0]  dq;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              qbit;
  logic [CNT_W-1:0]  rem_next;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial    = {rem, dq[SUM_W-1]};
    diff     = trial - {1'b0, dsr};
    qbit     = (trial >= {1'b0, dsr});
    rem_next = qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == ITER_W'(1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift dividend out and quotient in through one register
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= ITER_W'(SUM_W);
      dq  <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      cnt <= cnt - ITER_W'(1);
      dq  <= {dq[SUM_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign quotient  = dq;
  assign remainder = rem;

  `SWMMA_CHECK(a_no_restart, req.start, !busy, "divider restarted while busy")
  `SWMMA_CHECK_NEXT(a_start_busy, req.start, busy && !done, "divider did not start")
  `SWMMA_CHECK(a_done_idle, done, !busy && $past(busy), "done without a finished run")

endmodule

@@ hw/rtl/sliding_window_min_max_avg.sv @@
// ----------------------------------------------------------------------------
// sliding_window_min_max_avg
// Steps per word: one write, a scan of one memory read per cycle, a bit-serial
// divide, and a load of the result register, which waits while the output
// stalls. The block takes no new word until the result is loaded; the window
// read port and the shared divider serve one word at a time. A non
// power-of-two window adds one more divider run for the slot. Reset:
// synchronous, clears the window to zero through per-entry valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_min_max_avg_assert.svh"

module sliding_window_min_max_avg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  swmma_pkg::req_word_t req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output swmma_pkg::rsp_word_t rsp
);
  import swmma_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SLOT  = 6'b000010,
    S_WRITE = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t            state;
  state_t            state_next;
  win_ctrl_t         win;
  div_req_t          div_req;
  logic              div_done;
  logic [SUM_W-1:0]  div_quot;
  logic [CNT_W-1:0]  div_rem;
  logic [31:0]       rd_value;
  logic              rd_pend;
  logic              rsp_load;
  logic              pos;
  logic signed [31:0] latest;
  logic [ADDR_W-1:0] slot;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  acc_count;
  logic [SUM_W-1:0]  acc_sum;
  logic [30:0]       acc_lo;
  logic [30:0]       acc_hi;
  logic              empty;

  swmma_window u_window (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (win),
    .rd_value (rd_value)
  );

  swmma_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign req_stall = (state != S_IDLE);
  assign pos       = !rd_value[31] && (rd_value[30:0] != 31'd0);
  assign empty     = (acc_count == '0);

  // Sequence the slot divide of a non power-of-two window, write, scan, divide and result load
  always_comb begin
    state_next = state;
    win        = '0;
    div_req    = '0;
    rsp_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (WIN_POW2) begin
            state_next = S_WRITE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = SUM_W'(req.frame_index);
            div_req.divisor  = CNT_W'(WINDOW);
            state_next       = S_SLOT;
          end
        end
      end
      S_SLOT: begin
        if (div_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        win.wr_en   = 1'b1;
        win.wr_addr = slot;
        win.wr_data = latest;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        if (idx != IDX_W'(WINDOW)) begin
          win.rd_en   = 1'b1;
          win.rd_addr = idx[ADDR_W-1:0];
        end else if (!rd_pend) begin
          div_req.start    = 1'b1;
          div_req.dividend = acc_sum;
          div_req.divisor  = acc_count;
          state_next       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= win.rd_en;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Capture the word, accumulate the scan and hold the result
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && req_valid) begin
      latest <= req.sample;
      slot   <= req.frame_index[ADDR_W-1:0];
    end
    if ((state == S_SLOT) && div_done) begin
      slot <= div_rem[ADDR_W-1:0];
    end
    if (state == S_WRITE) begin
      idx       <= '0;
      acc_count <= '0;
      acc_sum   <= '0;
      acc_lo    <= '1;
      acc_hi    <= '0;
    end else begin
      if (win.rd_en) begin
        idx <= idx + IDX_W'(1);
      end
      if (rd_pend && pos) begin
        acc_count <= acc_count + CNT_W'(1);
        acc_sum   <= acc_sum + SUM_W'(rd_value[30:0]);
        if (rd_value[30:0] < acc_lo) begin
          acc_lo <= rd_value[30:0];
        end
        if (rd_value[30:0] > acc_hi) begin
          acc_hi <= rd_value[30:0];
        end
      end
    end
    if (rsp_load) begin
      rsp.latest      <= latest;
      rsp.valid_count <= OUT_CNT_W'(acc_count);
      rsp.minimum     <= empty ? 31'd0 : acc_lo;
      rsp.maximum     <= empty ? 31'd0 : acc_hi;
      rsp.average     <= empty ? 31'd0 : div_quot[30:0];
    end
  end

  `SWMMA_CHECK(a_count_range, state == S_DIV, acc_count <= CNT_W'(WINDOW), "count past window")
  `SWMMA_CHECK_NEXT(a_write_scan, state == S_WRITE, state == S_SCAN && idx == '0 && !rd_pend,
    "scan did not start after write")
  `SWMMA_CHECK(a_min_le_max, rsp_valid, rsp.minimum <= rsp.maximum, "minimum above maximum")
  `SWMMA_CHECK(a_empty_zero, rsp_valid && rsp.valid_count == '0,
    rsp.minimum == '0 && rsp.maximum == '0 && rsp.average == '0, "empty window not zero")

endmodule

@@ tb/sv/tb_sliding_window_min_max_avg.sv @@
// ----------------------------------------------------------------------------
// tb_sliding_window_min_max_avg
// Self-checking bench for the sliding window min/max/average block. Each
// accepted input word updates a local copy of the 64-entry window, and the
// bench predicts count, minimum, maximum and truncated average of the positive
// entries. Every result word is compared in order against those predictions.
// Directed cases cover empty windows, field extremes and slot wrap. Random
// frame runs, noise and a long output hold-off follow, and the run ends with
// a steady stream that has no idle cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sliding_window_min_max_avg;
  import swmma_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 150;

  logic      clk;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;

  // Local copy of the window and the results still owed by the block
  logic signed [31:0] window_copy [WINDOW];
  rsp_word_t          expected_stats [$];
  rsp_word_t          want;

  int errors = 0;
  int cycles = 0;
  bit sender_idle = 1'b1;
  bit receiver_idle = 1'b1;
  bit hold_req = 1'b0;
  int hold_len = 0;

  sliding_window_min_max_avg dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < WINDOW; i++) window_copy[i] = '0;
  end

  // Store the sample, then rescan the window for positive entries
  function automatic rsp_word_t compute_window_stats(req_word_t w);
    rsp_word_t   r;
    logic [63:0] total;
    int unsigned n;
    int unsigned slot;
    logic [30:0] lo;
    logic [30:0] hi;
    slot = w.frame_index % WINDOW;
    window_copy[slot] = w.sample;
    total = '0;
    n = 0;
    lo = 31'h7FFF_FFFF;
    hi = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if ($signed(window_copy[i]) > 0) begin
        n++;
        total += 64'(window_copy[i]);
        if (window_copy[i][30:0] < lo) lo = window_copy[i][30:0];
        if (window_copy[i][30:0] > hi) hi = window_copy[i][30:0];
      end
    end
    r.latest = w.sample;
    r.valid_count = OUT_CNT_W'(n);
    if (n > 0) begin
      r.minimum = lo;
      r.maximum = hi;
      r.average = 31'(total / 64'(n));
    end else begin
      r.minimum = '0;
      r.maximum = '0;
      r.average = '0;
    end
    return r;
  endfunction

  // Offer one word, hold it until taken, then maybe go idle for a burst
  task automatic send_word(input logic [31:0] frame, input logic [31:0] sample);
    req_word_t w;
    w.frame_index = frame;
    w.sample = sample;
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    expected_stats.insert(expected_stats.size(), compute_window_stats(w));
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Positive sample scattered around a center value
  function automatic logic [31:0] near_sample(logic [30:0] center);
    logic [31:0] s;
    s = {1'b0, center} + $urandom_range(0, (center >> 3) + 1);
    if (s[31] || s == 0) s = 32'h0000_0001;
    return s;
  endfunction

  // Receiver side: random stall bursts and the long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        rsp_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Compare each taken result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_stats.size() == 0) begin
        $error("result word with no prediction pending: %h", rsp);
        errors++;
      end else begin
        want = expected_stats.pop_front();
        if (rsp.latest !== want.latest) begin
          $error("latest: expected %h, actual %h", want.latest, rsp.latest);
          errors++;
        end
        if (rsp.valid_count !== want.valid_count) begin
          $error("valid_count: expected %0d, actual %0d", want.valid_count, rsp.valid_count);
          errors++;
        end
        if (rsp.minimum !== want.minimum) begin
          $error("minimum: expected %h, actual %h", want.minimum, rsp.minimum);
          errors++;
        end
        if (rsp.maximum !== want.maximum) begin
          $error("maximum: expected %h, actual %h", want.maximum, rsp.maximum);
          errors++;
        end
        if (rsp.average !== want.average) begin
          $error("average: expected %h, actual %h", want.average, rsp.average);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sliding_window_min_max_avg: FAIL");
      $finish;
    end
  end

  // Zero and negative samples only: the window stays empty
  task automatic test_empty_window();
    send_word(32'd0, 32'h0000_0000);
    send_word(32'd1, 32'hFFFF_FFFF);
    send_word(32'd2, 32'h8000_0000);
  endtask

  // Largest and smallest values, alternating bit patterns in both fields
  task automatic test_field_extremes();
    send_word(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_word(32'd3, 32'h0000_0001);
    send_word(32'h8000_0004, 32'h0001_0000);
    send_word(32'h5555_5555, 32'h2AAA_AAAA);
    send_word(32'hAAAA_AAAA, 32'h5555_5555);
    send_word(32'd5, 32'h0010_A3D7);
    // Drop the maximum by overwriting its slot with a negative sample
    send_word(32'd63, 32'hFFFF_FFFB);
  endtask

  // Frames that land on slots already in use
  task automatic test_slot_wrap();
    send_word(32'd64, 32'h7FFF_FFFF);
    send_word(32'd128, 32'h0000_0000);
    send_word(32'd7, 32'h0000_0002);
    send_word(32'd71, 32'h0000_0003);
    send_word(32'd135, 32'h8000_0001);
    send_word(32'h0000_0047, 32'h0000_0004);
    send_word(32'hFFFF_FFC0, 32'h0002_0000);
  endtask

  // Runs of consecutive frames with noise and saturated stretches between
  task automatic test_random_traffic(input int n_words);
    int          sent;
    int          run_len;
    int          kind;
    logic [31:0] frame;
    logic [30:0] center;
    logic [31:0] s;
    sent = 0;
    while (sent < n_words) begin
      kind = $urandom_range(0, 9);
      sender_idle = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      frame = $urandom();
      if (kind < 7) begin
        run_len = $urandom_range(8, 80);
        center = 31'($urandom() >> $urandom_range(1, 28));
        if (center == 0) center = 31'd1;
        for (int k = 0; k < run_len; k++) begin
          case ($urandom_range(0, 15))
            0: s = 32'h0000_0000;
            1: s = {1'b1, 31'($urandom())};
            default: s = near_sample(center);
          endcase
          send_word(frame + k, s);
        end
        sent += run_len;
      end else if (kind == 7) begin
        run_len = $urandom_range(64, 70);
        for (int k = 0; k < run_len; k++) begin
          send_word(frame + k, 32'h7FFF_FFFF - $urandom_range(0, 255));
        end
        sent += run_len;
      end else begin
        run_len = $urandom_range(1, 10);
        for (int k = 0; k < run_len; k++) send_word($urandom(), $urandom());
        sent += run_len;
      end
    end
  endtask

  // Hold results back long enough that the block stops taking words
  task automatic test_output_backpressure();
    logic [31:0] frame;
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    hold_len = 800;
    hold_req = 1'b1;
    frame = $urandom();
    for (int k = 0; k < 8; k++) send_word(frame + k, near_sample(31'h0010_0000));
  endtask

  // Back-to-back words with no idle cycles on either side
  task automatic test_steady_stream(input int n_words);
    logic [31:0] frame;
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    frame = $urandom();
    for (int k = 0; k < n_words; k++) begin
      send_word(frame + k, near_sample(31'h0010_A3D7));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_window();
    test_field_extremes();
    test_slot_wrap();
    test_random_traffic(420);
    test_output_backpressure();
    test_steady_stream(100);
    req_valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_sliding_window_min_max_avg: PASS");
    end else begin
      $display("tb_sliding_window_min_max_avg: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/swmma_pkg.sv
hw/rtl/swmma_window.sv
hw/rtl/swmma_div.sv
hw/rtl/sliding_window_min_max_avg.sv
tb/sv/tb_sliding_window_min_max_avg.sv
